[hdl/ssff_pkg.sv]
// Shared constants and types for the spectrum slope feature finder.
package ssff_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_STRATEGY      = 2'd0;
    localparam logic [1:0] REG_USE_LAST_DROP = 2'd1;
    localparam logic [1:0] REG_KERNEL_LENGTH = 2'd2;

    // Strategy codes
    localparam logic [1:0] STRAT_DROP = 2'd0;
    localparam logic [1:0] STRAT_MIN  = 2'd1;
    localparam logic [1:0] STRAT_MAX  = 2'd2;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int WAVE_W   = 24;
    localparam int SLOPE_W  = 32;
    localparam int INDEX_W  = 12;

    // Quotient of |num| << 16 is at most 41 bits; the divider walks all of them
    localparam int QUOT_W   = 41;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 32'sh8000_0000;

    // Slope handed from the divider to the trackers
    typedef struct packed {
        logic                       bad_step;
        logic signed [SLOPE_W-1:0]  slope;
    } t_slope;

endpackage

[hdl/spectrum_slope_feature_finder_unit.sv]
// Top level of the spectrum slope feature finder: delay line, serial divider, trackers.
//
// One sample is taken per transaction on the slave side. A sample that forms a slope
// with a rising wavelength passes through a load step, the radix-2 restoring divider
// that produces one quotient bit per cycle over all 41 quotient bits, and a tracker
// update; any other sample goes from the load straight to the tracker update. On a
// sample marked tlast one result transaction is offered on the master side, formed
// from the tracker registers that hold still until it is taken, and the window state
// then clears. Only one sample is in work at a time; s_axis_tready is high only when
// idle, so it is low while the divider runs, the trackers update or a result is waiting.
module spectrum_slope_feature_finder_unit #(
    parameter int MAX_KERNEL  = 16,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [23:0] intensity, [47:24] wavelength
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] point_index, [12] valid_res, [13] step_error, zero fill
    output logic [15:0] m_axis_tdata
);
    localparam int PTR_W = $clog2(MAX_KERNEL);
    localparam int CNT_W = $clog2(MAX_SAMPLES) + 1;
    localparam int KL_W  = $clog2(MAX_KERNEL + 1);
    localparam int QC_W  = 6;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // Configuration registers
    logic [1:0] r_strategy;
    logic       r_use_last;
    logic [4:0] r_kernel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= ssff_pkg::STRAT_DROP;
            r_use_last <= 1'b0;
            r_kernel   <= 5'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssff_pkg::REG_STRATEGY:      r_strategy <= i_cfg_data[1:0];
                ssff_pkg::REG_USE_LAST_DROP: r_use_last <= i_cfg_data[0];
                ssff_pkg::REG_KERNEL_LENGTH: r_kernel   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp kernel length into [2, MAX_KERNEL]
    logic [KL_W-1:0] w_k;
    always_comb begin
        if (r_kernel < 5'd2) w_k = KL_W'(2);
        else if (32'(r_kernel) > MAX_KERNEL) w_k = KL_W'(MAX_KERNEL);
        else w_k = KL_W'(r_kernel);
    end

    logic [1:0]  r_state;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [CNT_W-1:0] r_count;
    logic signed [ssff_pkg::SAMPLE_W-1:0] r_int_line [MAX_KERNEL];
    logic [ssff_pkg::WAVE_W-1:0]          r_wav_line [MAX_KERNEL];
    logic [MAX_KERNEL-1:0] r_line_vld;

    // Divider state
    logic [ssff_pkg::QUOT_W-1:0] r_quot;
    logic [ssff_pkg::WAVE_W:0]   r_rem;
    logic [ssff_pkg::WAVE_W-1:0] r_den;
    logic [QC_W-1:0]             r_qcnt;
    logic                        r_neg;
    logic                        r_bad;
    logic                        r_last;
    logic [CNT_W-1:0]            r_slope_idx;
    logic                        r_form_q;

    // Trackers
    logic [ssff_pkg::SLOPE_W-1:0]        r_la;
    logic [ssff_pkg::INDEX_W-1:0]        r_la_pos;
    logic signed [ssff_pkg::SLOPE_W-1:0] r_lo;
    logic [ssff_pkg::INDEX_W-1:0]        r_lo_pos;
    logic signed [ssff_pkg::SLOPE_W-1:0] r_hi;
    logic [ssff_pkg::INDEX_W-1:0]        r_hi_pos;
    logic [CNT_W-1:0] r_first_drop, r_last_drop;
    logic r_drop_found, r_prev_nn, r_err;

    logic [15:0] w_res;

    logic w_s_acc, w_m_acc;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = w_res;
    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_m_acc = m_axis_tvalid && m_axis_tready;

    // Incoming sample and the old one kernel_length-1 back
    logic signed [ssff_pkg::SAMPLE_W-1:0] w_s;
    logic [ssff_pkg::WAVE_W-1:0]          w_w;
    logic [PTR_W-1:0] w_back;
    logic [PTR_W-1:0] w_old_ptr;
    logic signed [ssff_pkg::SAMPLE_W-1:0] w_s_old;
    logic [ssff_pkg::WAVE_W-1:0]          w_w_old;
    logic signed [ssff_pkg::SAMPLE_W:0]   w_num;
    logic [ssff_pkg::SAMPLE_W:0]          w_mag;
    logic w_in_win, w_form;

    assign w_s = s_axis_tdata[23:0];
    assign w_w = s_axis_tdata[47:24];
    assign w_back = PTR_W'(w_k - KL_W'(1));
    // Step back around the ring of MAX_KERNEL entries
    assign w_old_ptr = (r_wr_ptr >= w_back) ? r_wr_ptr - w_back
                                            : r_wr_ptr + PTR_W'(MAX_KERNEL) - w_back;
    assign w_s_old = r_line_vld[w_old_ptr] ? r_int_line[w_old_ptr] : '0;
    assign w_w_old = r_line_vld[w_old_ptr] ? r_wav_line[w_old_ptr] : '0;
    assign w_num = (ssff_pkg::SAMPLE_W+1)'(w_s) - (ssff_pkg::SAMPLE_W+1)'(w_s_old);
    assign w_mag = w_num[ssff_pkg::SAMPLE_W] ? (ssff_pkg::SAMPLE_W+1)'(-w_num)
                                            : (ssff_pkg::SAMPLE_W+1)'(w_num);
    assign w_in_win = (32'(r_count) < MAX_SAMPLES);
    assign w_form = w_in_win && (r_count >= CNT_W'(w_k - KL_W'(1)));

    // One restoring step: shift in next dividend bit (top of r_quot)
    logic [ssff_pkg::WAVE_W+1:0] w_trial_rem;
    logic [ssff_pkg::WAVE_W+1:0] w_trial_sub;
    assign w_trial_rem = {r_rem, r_quot[ssff_pkg::QUOT_W-1]};
    assign w_trial_sub = w_trial_rem - {2'b00, r_den};

    // Saturate and sign the quotient
    ssff_pkg::t_slope w_sl;
    always_comb begin
        w_sl.bad_step = r_bad;
        if (r_bad) w_sl.slope = '0;
        else if (r_neg) begin
            if (r_quot >= ssff_pkg::QUOT_W'(33'h0_8000_0000)) w_sl.slope = ssff_pkg::SLOPE_MIN;
            else w_sl.slope = -$signed(r_quot[31:0]);
        end else begin
            if (r_quot > ssff_pkg::QUOT_W'(33'h0_7FFF_FFFF)) w_sl.slope = ssff_pkg::SLOPE_MAX;
            else w_sl.slope = $signed(r_quot[31:0]);
        end
    end

    logic [ssff_pkg::SLOPE_W-1:0] w_abs;
    logic [ssff_pkg::INDEX_W-1:0] w_pos;
    assign w_abs = w_sl.slope[31] ? 32'(-w_sl.slope) : 32'(w_sl.slope);
    assign w_pos = r_slope_idx[ssff_pkg::INDEX_W-1:0];

    // Result formed from the tracker state after the last update
    always_comb begin
        logic [CNT_W-1:0]             v_drop;
        logic [ssff_pkg::INDEX_W-1:0] v_idx;
        logic                         v_ok;
        v_drop = r_use_last ? r_last_drop : r_first_drop;
        v_idx  = '0;
        v_ok   = 1'b0;
        if (!r_err && (r_count >= CNT_W'(w_k))) begin
            v_ok = 1'b1;
            case (r_strategy)
                ssff_pkg::STRAT_DROP:
                    v_idx = r_drop_found ? ssff_pkg::INDEX_W'(v_drop - CNT_W'(1)) : r_la_pos;
                ssff_pkg::STRAT_MIN: v_idx = r_lo_pos;
                ssff_pkg::STRAT_MAX: v_idx = r_hi_pos;
                default: v_ok = 1'b0;
            endcase
        end
        if (v_ok) v_idx = v_idx + ssff_pkg::INDEX_W'(w_k >> 1);
        else v_idx = '0;
        w_res = {2'b00, r_err, v_ok, v_idx};
    end

    // Delay line payload
    always_ff @(posedge i_clk) begin
        if (w_s_acc && w_in_win) begin
            r_int_line[r_wr_ptr] <= w_s;
            r_wav_line[r_wr_ptr] <= w_w;
        end
    end

    // Divider payload: load on acceptance, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_quot      <= ssff_pkg::QUOT_W'({w_mag, 16'h0000});
            r_rem       <= '0;
            r_den       <= w_w - w_w_old;
            r_neg       <= w_num[ssff_pkg::SAMPLE_W];
            r_bad       <= (w_w <= w_w_old);
            r_qcnt      <= '0;
            r_last      <= s_axis_tlast;
            r_slope_idx <= r_count - CNT_W'(w_k - KL_W'(1));
        end else if (r_state == ST_DIV) begin
            if (w_trial_sub[ssff_pkg::WAVE_W+1]) begin
                r_rem  <= w_trial_rem[ssff_pkg::WAVE_W:0];
                r_quot <= {r_quot[ssff_pkg::QUOT_W-2:0], 1'b0};
            end else begin
                r_rem  <= w_trial_sub[ssff_pkg::WAVE_W:0];
                r_quot <= {r_quot[ssff_pkg::QUOT_W-2:0], 1'b1};
            end
            r_qcnt <= r_qcnt + QC_W'(1);
        end
    end

    // Control and trackers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wr_ptr     <= '0;
            r_count      <= '0;
            r_line_vld   <= '0;
            r_la <= '0; r_la_pos <= '0;
            r_lo <= '0; r_lo_pos <= '0;
            r_hi <= '0; r_hi_pos <= '0;
            r_first_drop <= '0; r_last_drop <= '0;
            r_drop_found <= 1'b0;
            r_prev_nn    <= 1'b0;
            r_err        <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        if (w_in_win) begin
                            r_line_vld[r_wr_ptr] <= 1'b1;
                            r_wr_ptr <= (r_wr_ptr == PTR_W'(MAX_KERNEL - 1)) ? '0
                                                                           : r_wr_ptr + PTR_W'(1);
                            r_count  <= r_count + CNT_W'(1);
                        end
                        r_state <= (w_form && (w_w > w_w_old)) ? ST_DIV : ST_UPD;
                    end
                end
                ST_DIV: begin
                    if (r_qcnt == QC_W'(ssff_pkg::QUOT_W - 1)) r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_state <= r_last ? ST_OUT : ST_IDLE;
                end
                ST_OUT: begin
                    if (w_m_acc) begin
                        r_state      <= ST_IDLE;
                        r_wr_ptr     <= '0;
                        r_count      <= '0;
                        r_line_vld   <= '0;
                        r_la <= '0; r_la_pos <= '0;
                        r_lo <= '0; r_lo_pos <= '0;
                        r_hi <= '0; r_hi_pos <= '0;
                        r_first_drop <= '0; r_last_drop <= '0;
                        r_drop_found <= 1'b0;
                        r_prev_nn    <= 1'b0;
                        r_err        <= 1'b0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // Slope update at the end of the divider run or a bad step
            if (r_state == ST_UPD && r_form_q) begin
                if (w_sl.bad_step) r_err <= 1'b1;
                if (r_slope_idx == '0) begin
                    r_la <= w_abs; r_la_pos <= '0;
                    r_lo <= w_sl.slope; r_lo_pos <= '0;
                    r_hi <= w_sl.slope; r_hi_pos <= '0;
                end else begin
                    if (w_abs < r_la) begin r_la <= w_abs; r_la_pos <= w_pos; end
                    if (w_sl.slope < r_lo) begin r_lo <= w_sl.slope; r_lo_pos <= w_pos; end
                    if (w_sl.slope > r_hi) begin r_hi <= w_sl.slope; r_hi_pos <= w_pos; end
                    if (w_sl.slope[31] && r_prev_nn) begin
                        if (!r_drop_found) r_first_drop <= r_slope_idx;
                        r_last_drop  <= r_slope_idx;
                        r_drop_found <= 1'b1;
                    end
                end
                r_prev_nn <= !w_sl.slope[31];
            end
        end
    end

    // Remember whether the accepted sample forms a slope
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_form_q <= 1'b0;
        else if (w_s_acc) r_form_q <= w_form;
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("sample taken while busy");
    a_out_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_UPD && r_last))
        else $error("result without last sample");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_qcnt < QC_W'(ssff_pkg::QUOT_W)))
        else $error("divider overran");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_m_acc |=> (r_count == '0 && !r_err))
        else $error("window not cleared after result");
`endif

endmodule

[dv/ssff_checker.sv]
// Checker for the slope feature finder: tracks the registers, predicts results, compares them.
module ssff_checker #(
    parameter int MAX_KERNEL  = 16,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    typedef struct packed {
        logic                         step_error;
        logic                         valid_res;
        logic [ssff_pkg::INDEX_W-1:0] point_index;
    } t_point;

    // Register copy
    logic [1:0] strategy;
    logic       use_last_drop;
    logic [4:0] kernel_length;

    // Window state
    logic signed [ssff_pkg::SAMPLE_W-1:0] intens_line [MAX_KERNEL];
    logic [ssff_pkg::WAVE_W-1:0]          wave_line   [MAX_KERNEL];
    int                                   wr_ptr;
    int                                   n_samples;
    logic [ssff_pkg::SLOPE_W-1:0]         min_abs;
    int                                   min_abs_pos;
    logic signed [ssff_pkg::SLOPE_W-1:0]  min_slope;
    int                                   min_pos;
    logic signed [ssff_pkg::SLOPE_W-1:0]  max_slope;
    int                                   max_pos;
    int                                   first_drop;
    int                                   last_drop;
    logic                                 drop_seen;
    logic                                 prev_nonneg;
    logic                                 bad_step_seen;

    t_point expected_points[$];

    assign o_pending = expected_points.size();

    function automatic logic signed [ssff_pkg::SLOPE_W-1:0] q16_slope(
            logic signed [ssff_pkg::SAMPLE_W:0] num, logic [ssff_pkg::WAVE_W-1:0] den);
        logic [63:0] mag;
        logic [63:0] quo;
        mag = (num < 0) ? 64'(-65'(num)) : 64'(num);
        quo = (mag << 16) / 64'(den);
        if (num < 0) begin
            if (quo >= 64'h8000_0000) return ssff_pkg::SLOPE_MIN;
            return -ssff_pkg::SLOPE_W'(quo);
        end
        if (quo > 64'h7FFF_FFFF) return ssff_pkg::SLOPE_MAX;
        return ssff_pkg::SLOPE_W'(quo);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < MAX_KERNEL; i++) begin
            intens_line[i] = '0;
            wave_line[i]   = '0;
        end
        wr_ptr = 0; n_samples = 0;
        min_abs = '0; min_abs_pos = 0;
        min_slope = '0; min_pos = 0;
        max_slope = '0; max_pos = 0;
        first_drop = 0; last_drop = 0;
        drop_seen = 1'b0; prev_nonneg = 1'b0; bad_step_seen = 1'b0;
    endtask

    // Update the trackers with one slope
    task automatic track_slope(logic signed [ssff_pkg::SLOPE_W-1:0] d, int idx);
        logic [ssff_pkg::SLOPE_W-1:0] mag;
        mag = (d < 0) ? ssff_pkg::SLOPE_W'(-d) : ssff_pkg::SLOPE_W'(d);
        if (idx == 0) begin
            min_abs = mag; min_abs_pos = 0;
            min_slope = d; min_pos = 0;
            max_slope = d; max_pos = 0;
        end else begin
            if (mag < min_abs) begin min_abs = mag; min_abs_pos = idx; end
            if (d < min_slope) begin min_slope = d; min_pos = idx; end
            if (d > max_slope) begin max_slope = d; max_pos = idx; end
            if (d < 0 && prev_nonneg) begin
                if (!drop_seen) first_drop = idx;
                last_drop = idx;
                drop_seen = 1'b1;
            end
        end
        prev_nonneg = (d >= 0);
    endtask

    // Predict the effect of one accepted sample
    task automatic take_sample(logic signed [ssff_pkg::SAMPLE_W-1:0] s,
                               logic [ssff_pkg::WAVE_W-1:0] w, logic last);
        int     k;
        int     old;
        int     idx;
        logic   ok;
        t_point pt;
        logic signed [ssff_pkg::SLOPE_W-1:0] d;
        k = int'(kernel_length);
        if (k < 2) k = 2;
        if (k > MAX_KERNEL) k = MAX_KERNEL;
        if (n_samples < MAX_SAMPLES) begin
            if (n_samples >= k - 1) begin
                old = (wr_ptr + MAX_KERNEL - (k - 1)) % MAX_KERNEL;
                d = '0;
                if (w <= wave_line[old]) bad_step_seen = 1'b1;
                else d = q16_slope((ssff_pkg::SAMPLE_W+1)'(s)
                                   - (ssff_pkg::SAMPLE_W+1)'(intens_line[old]),
                                   w - wave_line[old]);
                track_slope(d, n_samples - (k - 1));
            end
            intens_line[wr_ptr] = s;
            wave_line[wr_ptr]   = w;
            wr_ptr = (wr_ptr + 1) % MAX_KERNEL;
            n_samples++;
        end
        if (!last) return;
        idx = 0;
        ok  = 1'b0;
        if (!bad_step_seen && n_samples >= k) begin
            ok = 1'b1;
            case (strategy)
                ssff_pkg::STRAT_DROP: begin
                    if (drop_seen) idx = (use_last_drop ? last_drop : first_drop) - 1;
                    else idx = min_abs_pos;
                end
                ssff_pkg::STRAT_MIN: idx = min_pos;
                ssff_pkg::STRAT_MAX: idx = max_pos;
                default:             ok = 1'b0;
            endcase
        end
        idx = ok ? idx + k / 2 : 0;
        pt.point_index = ssff_pkg::INDEX_W'(idx);
        pt.valid_res   = ok;
        pt.step_error  = bad_step_seen;
        expected_points.push_back(pt);
        clear_window();
    endtask

    // Compare one delivered result with the oldest prediction
    task automatic check_point(t_point got);
        t_point exp_pt;
        if (expected_points.size() == 0) begin
            $error("unexpected result transaction: %h", got);
            o_fail_count++;
            return;
        end
        exp_pt = expected_points.pop_front();
        if (got.point_index !== exp_pt.point_index) begin
            $error("point_index: expected %0d, actual %0d", exp_pt.point_index, got.point_index);
            o_fail_count++;
        end
        if (got.valid_res !== exp_pt.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", exp_pt.valid_res, got.valid_res);
            o_fail_count++;
        end
        if (got.step_error !== exp_pt.step_error) begin
            $error("step_error: expected %0d, actual %0d", exp_pt.step_error, got.step_error);
            o_fail_count++;
        end
        o_result_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
    end

    // Watch the channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            strategy      = ssff_pkg::STRAT_DROP;
            use_last_drop = 1'b0;
            kernel_length = 5'd2;
            clear_window();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ssff_pkg::REG_STRATEGY:      strategy      = i_cfg_data[1:0];
                    ssff_pkg::REG_USE_LAST_DROP: use_last_drop = i_cfg_data[0];
                    ssff_pkg::REG_KERNEL_LENGTH: kernel_length = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                take_sample(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_point(m_axis_tdata[13:0]);
        end
    end

    final begin
        if (expected_points.size() != 0)
            $error("%0d expected results never arrived", expected_points.size());
    end

endmodule

[dv/testbench.sv]
// Top of the slope feature finder testbench: clock, reset, stimulus and verdict.
module testbench;

    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE     = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   result_count;
    int   sample_count;
    int   window_count;
    int   cycle_count;
    int   idle_cycles;
    logic sender_steady;
    logic hold_request;
    int   hold_left;
    logic [ssff_pkg::WAVE_W-1:0] wave_now;

    spectrum_slope_feature_finder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ssff_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, a steady stretch, and one long hold-off on request
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (hold_request && hold_left == 0) begin
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_left == 1) hold_left <= -1;
            if (cycle_count > 30000 && cycle_count < 60000) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(99) >= 27);
        end
    end

    // Watchdog on accepted transactions
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] index, logic [4:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Offer one sample and hold it until accepted
    task automatic send_sample(logic signed [ssff_pkg::SAMPLE_W-1:0] s,
                               logic [ssff_pkg::WAVE_W-1:0] w, logic last);
        int gap;
        if (!sender_steady && $urandom_range(99) < 27) begin
            gap = $urandom_range(4, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w, s};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sample_count++;
    endtask

    // Let all predicted results drain, plus the block's own latency
    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > 20000) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One window: a wandering intensity over increasing wavelengths, with rare bad steps
    task automatic send_window(int len, int bad_pct);
        logic signed [ssff_pkg::SAMPLE_W:0] s;
        int                                 dir;
        int                                 step;
        s = $urandom_range(2) == 0 ? $signed(25'($urandom_range(16777215)) - 25'sd8388608)
                                   : 25'sd0;
        dir = $urandom_range(1) ? 1 : -1;
        wave_now = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(4000));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 20) dir = -dir;
            step = $urandom_range(3) == 0 ? $urandom_range(8388607)
                                          : $urandom_range(60000);
            s = 25'(s + dir * step);
            if (s > 25'sd8388607)  s = 25'sd8388607;
            if (s < -25'sd8388608) s = -25'sd8388608;
            if ($urandom_range(99) < bad_pct)
                wave_now = wave_now - 24'($urandom_range(3));
            else if ($urandom_range(9) == 0)
                wave_now = wave_now + 24'($urandom_range(65535, 1));
            else
                wave_now = wave_now + 24'($urandom_range(40, 1));
            send_sample(s[ssff_pkg::SAMPLE_W-1:0], wave_now, i == len - 1);
        end
        window_count++;
    endtask

    initial begin
        logic [4:0] kernels [10];
        int         kernel_pick;
        int         win_len;
        kernels = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd9, 5'd17, 5'd1, 5'd5, 5'd12};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = ssff_pkg::REG_STRATEGY;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        hold_request  = 1'b0;
        hold_left     = 0;
        sender_steady = 1'b0;
        cycle_count   = 0;
        idle_cycles   = 0;
        sample_count  = 0;
        window_count  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone sample, saturated slopes both ways, a rise then a drop,
        // a repeated and a falling wavelength
        send_sample(24'sd5, 24'd10, 1'b1);
        send_sample(24'sh7FFFFF, 24'd0, 1'b0);
        send_sample(-24'sh800000, 24'd1, 1'b0);
        send_sample(24'sh7FFFFF, 24'd2, 1'b1);
        send_sample(24'sd0, 24'd100, 1'b0);
        send_sample(24'sd500, 24'd110, 1'b0);
        send_sample(24'sd900, 24'd120, 1'b0);
        send_sample(24'sd200, 24'd130, 1'b0);
        send_sample(24'sd300, 24'd140, 1'b0);
        send_sample(-24'sd100, 24'd150, 1'b1);
        send_sample(24'sd7, 24'hFFFFF0, 1'b0);
        send_sample(24'sd8, 24'hFFFFF0, 1'b1);
        send_sample(24'sd7, 24'hFFFFFF, 1'b0);
        send_sample(24'sd9, 24'h000001, 1'b1);
        drain();

        // Phases over all strategy codes and drop choices and a spread of kernel lengths
        for (int ph = 0; ph < 22; ph++) begin
            kernel_pick = ph % 10;
            write_reg(ssff_pkg::REG_STRATEGY, 5'(ph % 4));
            write_reg(ssff_pkg::REG_USE_LAST_DROP, 5'((ph / 4) % 2));
            write_reg(ssff_pkg::REG_KERNEL_LENGTH, kernels[kernel_pick]);
            sender_steady = (ph == 6 || ph == 7);
            if (ph == 3) hold_request = 1'b1;
            for (int w = 0; w < 6; w++) begin
                win_len = $urandom_range(3) == 0 ? $urandom_range(3, 1)
                                                 : $urandom_range(20, 4);
                send_window(win_len, (w == 5) ? 8 : 0);
                hold_request = 1'b0;
            end
            drain();
        end

        // Longer steady window with a late maximum
        write_reg(ssff_pkg::REG_STRATEGY, 5'(ssff_pkg::STRAT_MAX));
        write_reg(ssff_pkg::REG_KERNEL_LENGTH, 5'd4);
        sender_steady = 1'b1;
        for (int i = 0; i < 64; i++)
            send_sample(24'(i < 60 ? i * 100 : 8000000), 24'(i * 2 + 1), i == 63);
        window_count++;
        drain();

        $display("Ran %0d windows of %0d samples through all strategies and kernels,",
                 window_count, sample_count);
        $display("including saturation, bad steps and a long receiver hold-off; %0d results.",
                 result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
